FILE: rtl/core/dltm_pkg.sv
// package: widths, command codes and sequencer states of the delta-list timer manager
package dltm_pkg;
   localparam int NUM_TIMERS   = 16;
   localparam int TIMEOUT_BITS = 32;
   localparam int ID_BITS      = $clog2(NUM_TIMERS);
   localparam int LINK_BITS    = ID_BITS + 1;
   localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(NUM_TIMERS);

   typedef logic [TIMEOUT_BITS-1:0] tick_type;
   typedef logic [LINK_BITS-1:0]    link_type;
   typedef logic [ID_BITS-1:0]      id_type;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_START   = 2'd1,
      CMD_STOP    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RM_WALK,
      ST_RM_FIX,
      ST_INS_CHECK,
      ST_INS_WALK,
      ST_INS_LINK,
      ST_NOW_OUT,
      ST_TICK_DEC,
      ST_TICK_POP,
      ST_TICK_OUT,
      ST_RELOAD_NEXT
   } state_type;

   typedef enum logic [1:0] {
      ALU_SUB,
      ALU_ADD,
      ALU_DEC
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      tick_type   a;
      tick_type   b;
   } alu_req_type;

   typedef struct packed {
      tick_type sum;
      logic     zero;
      logic     borrow;
   } alu_rsp_type;
endpackage

FILE: rtl/core/dltm_alu.sv
// module: shared add / subtract / decrement unit with zero and borrow flags
module dltm_alu
   import dltm_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);
   logic [TIMEOUT_BITS:0] wide;

   always_comb begin
      case (req.op)
         ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
         ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
         ALU_DEC: wide = {1'b0, req.a} - (TIMEOUT_BITS+1)'(1);
         default: wide = '0;
      endcase
      rsp.sum    = wide[TIMEOUT_BITS-1:0];
      rsp.zero   = (wide[TIMEOUT_BITS-1:0] == '0);
      rsp.borrow = wide[TIMEOUT_BITS];
   end
endmodule

FILE: rtl/core/delta_list_timer_manager_unit.sv
// top level: delta-list timer manager with walking sequencer and shared alu
// One request at a time. The sequencer walks the linked list one entry per
// cycle through a single add/subtract unit. Start and restart walk the list
// once to unlink a waiting timer and once to insert; stop only unlinks. A
// tick decrements the head, then pops, outputs and reload-scans each expiring
// timer, with one insertion walk for each periodic expiry; output handshake
// stalls hold the sequencer.
// Each expiry is offered as a response of its own; the final one of
// a request has rsp_last set. req_ready is high only while the sequencer is
// idle; a pending response holds off new requests until taken.
module delta_list_timer_manager_unit
   import dltm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_timer_id,
   input  logic [31:0] req_timeout,
   input  logic        req_periodic,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_expired_id,
   output logic        rsp_last
);
   // timer state, small enough for flip-flops
   tick_type delta_ff  [NUM_TIMERS];
   tick_type reload_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] per_ff, wait_ff;
   link_type next_ff   [NUM_TIMERS];
   link_type head_ff;

   // sequencer registers
   state_type state_ff, state_in;
   id_type    slot_ff;           // slot being armed / stopped
   tick_type  t_ff;              // remaining insert value
   link_type  cur_ff, prev_ff;
   logic      ins_after_ff;      // arm after unlink
   logic [NUM_TIMERS-1:0] fired_ff; // expired slots awaiting reload
   id_type    fired_q_ff [NUM_TIMERS]; // expiry order
   logic [ID_BITS:0] nfired_ff, rl_idx_ff;
   logic      rsp_valid_ff;
   id_type    rsp_id_ff;
   logic      rsp_last_ff;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   dltm_alu u_alu (.req(alu_req), .rsp(alu_rsp));

   id_type cur_id, prev_id, head_id, rl_slot;
   logic   cur_ok, prev_ok, head_ok;
   assign cur_id  = cur_ff[ID_BITS-1:0];
   assign prev_id = prev_ff[ID_BITS-1:0];
   assign head_id = head_ff[ID_BITS-1:0];
   assign cur_ok  = (cur_ff  < NULL_LINK);
   assign prev_ok = (prev_ff < NULL_LINK);
   assign head_ok = (head_ff < NULL_LINK);
   assign rl_slot = fired_q_ff[rl_idx_ff[ID_BITS-1:0]];

   assign req_ready      = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_expired_id = 4'(rsp_id_ff);
   assign rsp_last       = rsp_last_ff;

   logic req_acc, rsp_free, rsp_load;
   assign req_acc  = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   // a new response enters the output register this cycle
   assign rsp_load = rsp_free && ((state_ff == ST_NOW_OUT) || (state_ff == ST_TICK_OUT));

   // slot id of request, range check for narrow parameter values
   logic id_ok;
   assign id_ok = ({1'b0, req_timer_id} < 5'(NUM_TIMERS));

   // alu operand selection
   always_comb begin
      alu_req.op = ALU_SUB;
      alu_req.a  = t_ff;
      alu_req.b  = delta_ff[cur_id];
      case (state_ff)
         ST_RM_FIX: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = delta_ff[next_ff[slot_ff][ID_BITS-1:0]];
            alu_req.b  = delta_ff[slot_ff];
         end
         ST_TICK_DEC: begin
            alu_req.op = ALU_DEC;
            alu_req.a  = delta_ff[head_id];
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_acc && (req_cmd == CMD_TICK) && head_ok) state_in = ST_TICK_DEC;
            else if (req_acc && (req_cmd != CMD_TICK) && id_ok) begin
               if (wait_ff[req_timer_id[ID_BITS-1:0]]) state_in = ST_RM_WALK;
               else if (req_cmd == CMD_STOP) state_in = ST_IDLE;
               else state_in = ST_INS_CHECK;
            end
         ST_RM_WALK:
            if (cur_id == slot_ff) state_in = ST_RM_FIX;
         ST_RM_FIX:
            state_in = ins_after_ff ? ST_INS_CHECK : ST_IDLE;
         ST_INS_CHECK:
            state_in = (t_ff == '0) ? ST_NOW_OUT : ST_INS_WALK;
         ST_INS_WALK:
            if (!cur_ok || alu_rsp.borrow) state_in = ST_INS_LINK;
         ST_INS_LINK:
            state_in = (fired_ff != '0) ? ST_RELOAD_NEXT : ST_IDLE;
         ST_NOW_OUT:
            if (rsp_free) state_in = ST_IDLE;
         ST_TICK_DEC:
            state_in = ((delta_ff[head_id] == '0) || alu_rsp.zero) ? ST_TICK_POP
                                                                    : ST_IDLE;
         ST_TICK_POP:
            state_in = ST_TICK_OUT;
         ST_TICK_OUT:
            if (rsp_free) begin
               if (head_ok && delta_ff[head_id] == '0) state_in = ST_TICK_POP;
               else state_in = ST_RELOAD_NEXT;
            end
         ST_RELOAD_NEXT:
            if (rl_idx_ff >= nfired_ff) state_in = ST_IDLE;
            else if (per_ff[rl_slot]) state_in = ST_INS_CHECK;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and list updates
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NULL_LINK;
         wait_ff      <= '0;
         per_ff       <= '0;
         fired_ff     <= '0;
         nfired_ff    <= '0;
         rl_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            delta_ff[i]  <= '0;
            reload_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready && !rsp_load) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE:
               if (req_acc) begin
                  slot_ff      <= req_timer_id[ID_BITS-1:0];
                  cur_ff       <= head_ff;
                  prev_ff      <= NULL_LINK;
                  ins_after_ff <= (req_cmd != CMD_STOP);
                  fired_ff     <= '0;
                  nfired_ff    <= '0;
                  rl_idx_ff    <= '0;
                  if (id_ok && req_cmd == CMD_START) begin
                     // periodic zero becomes one
                     t_ff <= (req_periodic && req_timeout[TIMEOUT_BITS-1:0] == '0)
                             ? tick_type'(1) : req_timeout[TIMEOUT_BITS-1:0];
                     reload_ff[req_timer_id[ID_BITS-1:0]] <=
                        (req_periodic && req_timeout[TIMEOUT_BITS-1:0] == '0)
                        ? tick_type'(1) : req_timeout[TIMEOUT_BITS-1:0];
                     per_ff[req_timer_id[ID_BITS-1:0]] <= req_periodic;
                  end else if (id_ok) begin
                     t_ff <= reload_ff[req_timer_id[ID_BITS-1:0]];
                  end
               end
            ST_RM_WALK:
               if (cur_id != slot_ff) begin
                  prev_ff <= cur_ff;
                  cur_ff  <= next_ff[cur_id];
               end
            ST_RM_FIX: begin
               // removed delta moves to the successor, if any
               if (next_ff[slot_ff] < NULL_LINK)
                  delta_ff[next_ff[slot_ff][ID_BITS-1:0]] <= alu_rsp.sum;
               if (prev_ok) next_ff[prev_id] <= next_ff[slot_ff];
               else         head_ff <= next_ff[slot_ff];
               wait_ff[slot_ff] <= 1'b0;
               cur_ff  <= (prev_ok) ? head_ff :
                          ((next_ff[slot_ff] < NULL_LINK) ? next_ff[slot_ff] : NULL_LINK);
               prev_ff <= NULL_LINK;
            end
            ST_INS_CHECK: begin
               cur_ff  <= head_ff;
               prev_ff <= NULL_LINK;
               // zero one-shot: the response follows in the next state
               if (t_ff == '0) delta_ff[slot_ff] <= '0;
            end
            ST_INS_WALK:
               if (cur_ok) begin
                  if (alu_rsp.borrow) begin
                     // successor keeps the remainder
                     delta_ff[cur_id] <= delta_ff[cur_id] - t_ff;
                  end else begin
                     t_ff    <= alu_rsp.sum;
                     prev_ff <= cur_ff;
                     cur_ff  <= next_ff[cur_id];
                  end
               end
            ST_INS_LINK: begin
               delta_ff[slot_ff] <= t_ff;
               next_ff[slot_ff]  <= cur_ok ? cur_ff : NULL_LINK;
               if (prev_ok) next_ff[prev_id] <= {1'b0, slot_ff};
               else         head_ff <= {1'b0, slot_ff};
               wait_ff[slot_ff] <= 1'b1;
            end
            ST_NOW_OUT:
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_id_ff    <= slot_ff;
                  rsp_last_ff  <= 1'b1;
               end
            ST_TICK_DEC:
               if (delta_ff[head_id] != '0) delta_ff[head_id] <= alu_rsp.sum;
            ST_TICK_POP: begin
               slot_ff <= head_id;
               fired_ff[head_id] <= 1'b1;
               fired_q_ff[nfired_ff[ID_BITS-1:0]] <= head_id;
               nfired_ff <= nfired_ff + 1'b1;
               wait_ff[head_id] <= 1'b0;
               head_ff <= (next_ff[head_id] < NULL_LINK) ? next_ff[head_id] : NULL_LINK;
            end
            ST_TICK_OUT:
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_id_ff    <= slot_ff;
                  rsp_last_ff  <= !(head_ok && delta_ff[head_id] == '0);
               end
            ST_RELOAD_NEXT:
               if (rl_idx_ff < nfired_ff) begin
                  rl_idx_ff <= rl_idx_ff + 1'b1;
                  slot_ff   <= rl_slot;
                  t_ff      <= reload_ff[rl_slot];
               end else begin
                  fired_ff <= '0;
               end
            default: ;
         endcase
      end
   end
endmodule

FILE: rtl/core/dltm_checker.sv
// checker: port-level properties of the timer manager, bound to the top level
module dltm_port_checker
   import dltm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_expired_id,
   input logic       rsp_last
);
   // response holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_expired_id) && $stable(rsp_last))
      else $error("response changed while stalled");

   // no new request while a response is pending
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while response pending");

   // nothing pending right after reset
   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response after reset");

   // after an accepted request, ready and a pending response are never both high next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready || !rsp_valid)
      else $error("ready with response after request");
endmodule

bind delta_list_timer_manager_unit dltm_port_checker u_dltm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_expired_id(rsp_expired_id),
   .rsp_last(rsp_last)
);
